### rtl/core/jrc_pkg.sv
package jrc_pkg;

    localparam int unsigned CNT_W = 33;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [31:0] RST_FILE_MAGIC   = 32'h4744_5131;
    localparam logic [31:0] RST_VERSION      = 32'd1;
    localparam logic [31:0] RST_RECORD_MAGIC = 32'h4451_5231;
    localparam logic [15:0] RST_MAX_NAME     = 16'd4096;
    localparam logic [31:0] RST_MAX_PAYLOAD  = 32'd268435456;

    localparam logic [2:0] CFG_FILE_MAGIC   = 3'd0;
    localparam logic [2:0] CFG_VERSION      = 3'd1;
    localparam logic [2:0] CFG_RECORD_MAGIC = 3'd2;
    localparam logic [2:0] CFG_MAX_NAME     = 3'd3;
    localparam logic [2:0] CFG_MAX_PAYLOAD  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_FILE   = 3'd1;
    localparam logic [2:0] ST_TORN       = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd3;
    localparam logic [2:0] ST_OVER_LIMIT = 3'd4;
    localparam logic [2:0] ST_BAD_SUM    = 3'd5;
    localparam logic [2:0] ST_CLEAN_END  = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        end_of_journal;
        logic [7:0]  record_type;
        logic [63:0] sequence_res;
        logic [15:0] name_length;
        logic [31:0] payload_length;
        logic [63:0] next_sequence;
    } res_t;

endpackage

### rtl/core/jrc_in_reg.sv
module jrc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  jrc_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output jrc_pkg::item_t item
);
    import jrc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/core/jrc_core.sv
module jrc_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_wr_data,
    input  logic           step,
    input  jrc_pkg::item_t item,
    output logic           res_have,
    output jrc_pkg::res_t  res
);
    import jrc_pkg::*;

    localparam logic [2:0] PH_FILE = 3'd0;
    localparam logic [2:0] PH_RHDR = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_CRC  = 3'd3;
    localparam logic [2:0] PH_STOP = 3'd4;

    logic [31:0] file_magic_reg;
    logic [31:0] version_reg;
    logic [31:0] record_magic_reg;
    logic [15:0] max_name_reg;
    logic [31:0] max_payload_reg;

    logic [2:0]       phase_reg,   phase_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [31:0]      hword_reg,   hword_next;
    logic [7:0]       type_reg,    type_next;
    logic [15:0]      name_reg,    name_next;
    logic [31:0]      pay_reg,     pay_next;
    logic [63:0]      seq_reg,     seq_next;
    logic [31:0]      hash_reg,    hash_next;
    logic [31:0]      sum_reg,     sum_next;
    logic [63:0]      high_reg,    high_next;

    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] body_len;
    logic [31:0]      hash_step;
    logic [63:0]      seq_inc;
    logic [63:0]      high_upd;
    logic [2:0]       status;
    logic             have;
    logic             last;
    logic [7:0]       b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_magic_reg   <= RST_FILE_MAGIC;
            version_reg      <= RST_VERSION;
            record_magic_reg <= RST_RECORD_MAGIC;
            max_name_reg     <= RST_MAX_NAME;
            max_payload_reg  <= RST_MAX_PAYLOAD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_FILE_MAGIC:   file_magic_reg   <= cfg_wr_data;
                CFG_VERSION:      version_reg      <= cfg_wr_data;
                CFG_RECORD_MAGIC: record_magic_reg <= cfg_wr_data;
                CFG_MAX_NAME:     max_name_reg     <= cfg_wr_data[15:0];
                CFG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign b         = item.data_byte;
    assign last      = item.stream_end;
    assign count_inc = count_reg + 1'b1;
    assign body_len  = {{(CNT_W-16){1'b0}}, name_reg} + {{(CNT_W-32){1'b0}}, pay_reg};
    assign hash_step = (hash_reg ^ {24'd0, b}) * FNV_PRIME;
    assign seq_inc   = seq_reg + 64'd1;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        hword_next = hword_reg;
        type_next  = type_reg;
        name_next  = name_reg;
        pay_next   = pay_reg;
        seq_next   = seq_reg;
        hash_next  = hash_reg;
        sum_next   = sum_reg;
        high_upd   = high_reg;
        have       = 1'b0;
        status     = ST_OK;

        unique case (phase_reg)
            PH_FILE: begin
                hword_next = {b, hword_reg[31:8]};
                count_next = count_inc;
                if (count_inc == CNT_W'(4) && hword_next != file_magic_reg) begin
                    have = 1'b1; status = ST_BAD_FILE; phase_next = PH_STOP;
                end else if (count_inc == CNT_W'(8)) begin
                    if (hword_next != version_reg) begin
                        have = 1'b1; status = ST_BAD_FILE; phase_next = PH_STOP;
                    end else begin
                        phase_next = PH_RHDR;
                        count_next = '0;
                        hword_next = '0;
                        if (last) begin
                            have = 1'b1; status = ST_CLEAN_END;
                        end
                    end
                end else if (last) begin
                    have = 1'b1; status = ST_BAD_FILE;
                end
            end
            PH_RHDR: begin
                hash_next = hash_step;
                if (count_reg < CNT_W'(4)) begin
                    hword_next = {b, hword_reg[31:8]};
                end else if (count_reg == CNT_W'(4)) begin
                    type_next = b;
                end else if (count_reg == CNT_W'(6) || count_reg == CNT_W'(7)) begin
                    name_next = {b, name_reg[15:8]};
                end else if (count_reg >= CNT_W'(8) && count_reg < CNT_W'(12)) begin
                    pay_next = {b, pay_reg[31:8]};
                end else if (count_reg >= CNT_W'(12)) begin
                    seq_next = {b, seq_reg[63:8]};
                end
                count_next = count_inc;
                if (count_inc >= CNT_W'(20)) begin
                    if (hword_next != record_magic_reg) begin
                        have = 1'b1; status = ST_BAD_MAGIC; phase_next = PH_STOP;
                    end else if (name_next > max_name_reg || pay_next > max_payload_reg) begin
                        have = 1'b1; status = ST_OVER_LIMIT; phase_next = PH_STOP;
                    end else begin
                        count_next = '0;
                        phase_next = (name_next == 16'd0 && pay_next == 32'd0) ? PH_CRC : PH_BODY;
                        if (last) begin
                            have = 1'b1; status = ST_TORN;
                        end
                    end
                end else if (last) begin
                    have = 1'b1; status = ST_TORN;
                end
            end
            PH_BODY: begin
                hash_next  = hash_step;
                count_next = count_inc;
                if (count_inc >= body_len) begin
                    phase_next = PH_CRC;
                    count_next = '0;
                end
                if (last) begin
                    have = 1'b1; status = ST_TORN;
                end
            end
            PH_CRC: begin
                sum_next   = {b, sum_reg[31:8]};
                count_next = count_inc;
                if (count_inc >= CNT_W'(4)) begin
                    have = 1'b1;
                    if (sum_next != hash_reg) begin
                        status = ST_BAD_SUM; phase_next = PH_STOP;
                    end else begin
                        if (seq_reg >= high_reg) begin
                            high_upd = seq_inc;
                        end
                        status     = ST_OK;
                        phase_next = PH_RHDR;
                        count_next = '0;
                        hash_next  = FNV_BASIS;
                        hword_next = '0;
                    end
                end else if (last) begin
                    have = 1'b1; status = ST_TORN;
                end
            end
            default: ;
        endcase

        high_next = high_upd;
        if (last) begin
            phase_next = PH_FILE;
            count_next = '0;
            hword_next = '0;
            type_next  = '0;
            name_next  = '0;
            pay_next   = '0;
            seq_next   = '0;
            hash_next  = FNV_BASIS;
            sum_next   = '0;
            high_next  = 64'd1;
        end
    end

    always_comb begin
        res.status         = status;
        res.end_of_journal = last || (status != ST_OK);
        res.record_type    = (status == ST_OK) ? type_reg : 8'd0;
        res.sequence_res   = (status == ST_OK) ? seq_reg  : 64'd0;
        res.name_length    = (status == ST_OK) ? name_reg : 16'd0;
        res.payload_length = (status == ST_OK) ? pay_reg  : 32'd0;
        res.next_sequence  = high_upd;
    end

    assign res_have = have;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FILE;
            count_reg <= '0;
            hword_reg <= '0;
            type_reg  <= '0;
            name_reg  <= '0;
            pay_reg   <= '0;
            seq_reg   <= '0;
            hash_reg  <= FNV_BASIS;
            sum_reg   <= '0;
            high_reg  <= 64'd1;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            hword_reg <= hword_next;
            type_reg  <= type_next;
            name_reg  <= name_next;
            pay_reg   <= pay_next;
            seq_reg   <= seq_next;
            hash_reg  <= hash_next;
            sum_reg   <= sum_next;
            high_reg  <= high_next;
        end
    end

endmodule

### rtl/core/jrc_out_reg.sv
module jrc_out_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          load,
    input  jrc_pkg::res_t res,
    output logic          busy,
    output logic          m_valid,
    input  logic          m_ready,
    output jrc_pkg::res_t m_res
);
    import jrc_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign busy       = valid_reg && !m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

### rtl/core/journal_record_checker_fnv1a.sv
// Channel   Direction  Handshake         Word
// s_        in         s_valid/s_ready   s_data_byte, s_stream_end
// m_        out        m_valid/m_ready   status, end_of_journal, record fields, next_sequence
// cfg_      in         cfg_wr_en         cfg_index, cfg_wr_data
//
// One byte per cycle sustained while no output word is stalled; a word is loaded into the
// output register from the byte in the input register whenever that register is free.
// The whole per-byte step (FNV-1a multiply, field capture, checks) sits between the input
// register and the output register.
// While the output word stalls, bytes that give no word still advance; a byte that gives one
// waits in the input register and s_ready drops until the output drains.
// aresetn is synchronous, active low, and restores the configuration reset values.
module journal_record_checker_fnv1a (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_end_of_journal,
    output logic [7:0]  m_record_type,
    output logic [63:0] m_sequence_res,
    output logic [15:0] m_name_length,
    output logic [31:0] m_payload_length,
    output logic [63:0] m_next_sequence,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data
);
    import jrc_pkg::*;

    item_t s_item;
    item_t item;
    logic  item_valid;
    logic  take;
    logic  res_have;
    logic  out_busy;
    res_t  res;
    res_t  m_res;

    assign s_item.data_byte  = s_data_byte;
    assign s_item.stream_end = s_stream_end;

    assign take = item_valid && !(res_have && out_busy);

    jrc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    jrc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .step        (take),
        .item        (item),
        .res_have    (res_have),
        .res         (res)
    );

    jrc_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (take && res_have),
        .res     (res),
        .busy    (out_busy),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_status         = m_res.status;
    assign m_end_of_journal = m_res.end_of_journal;
    assign m_record_type    = m_res.record_type;
    assign m_sequence_res   = m_res.sequence_res;
    assign m_name_length    = m_res.name_length;
    assign m_payload_length = m_res.payload_length;
    assign m_next_sequence  = m_res.next_sequence;

endmodule

### rtl/core/jrc_checker.sv
module jrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic        m_end_of_journal,
    input logic [7:0]  m_record_type,
    input logic [63:0] m_sequence_res,
    input logic [15:0] m_name_length,
    input logic [31:0] m_payload_length
);
    import jrc_pkg::*;

    a_stop_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_end_of_journal)
        else $error("stop status without end of journal");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |->
            m_record_type == 8'd0 && m_sequence_res == 64'd0 &&
            m_name_length == 16'd0 && m_payload_length == 32'd0)
        else $error("record fields set on a non-record word");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_CLEAN_END)
        else $error("status code out of range");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_sequence_res))
        else $error("output word dropped or changed while stalled");

endmodule

bind journal_record_checker_fnv1a jrc_checker u_jrc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_end_of_journal (m_end_of_journal),
    .m_record_type    (m_record_type),
    .m_sequence_res   (m_sequence_res),
    .m_name_length    (m_name_length),
    .m_payload_length (m_payload_length)
);
